// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; they compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, cond, res)
`endif
`endif

// ===== rtl/pwns_pkg.sv =====
// Types and constants of the perspective warp nearest sampler.
`default_nettype none
package pwns_pkg;

    localparam int SRC_MAX_WIDTH  = 512;
    localparam int SRC_MAX_HEIGHT = 512;
    localparam int DEST_SIZE      = 64;

    localparam int LOAD_X_W = $clog2(SRC_MAX_WIDTH);
    localparam int LOAD_Y_W = $clog2(SRC_MAX_HEIGHT);
    localparam int PIX_W    = 8;
    localparam int DEST_W   = $clog2(DEST_SIZE);
    localparam int MEM_AW   = $clog2(SRC_MAX_WIDTH * SRC_MAX_HEIGHT);
    localparam int MEM_DEPTH = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;

    localparam int COEF_W     = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_SIZE_W = 10;

    // quotient bits needed to cover the larger source side
    localparam int QB = (LOAD_X_W > LOAD_Y_W) ? LOAD_X_W : LOAD_Y_W;

    // product, sum and rounded-numerator widths
    localparam int PW = COEF_W + DEST_W + 1;
    localparam int SW = PW + 2;
    localparam int NW = SW + 2;
    localparam int DW = NW + QB;
    localparam int CW = (QB + 1 > CFG_SIZE_W) ? QB + 1 : CFG_SIZE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_M0_M1    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_M2_M3    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_M4_M5    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_M6_M7    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_M8       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_VALUE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd7;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [LOAD_X_W-1:0] load_x;
        logic [LOAD_Y_W-1:0] load_y;
        logic [PIX_W-1:0]    load_pixel;
        logic [DEST_W-1:0]   dest_row;
        logic [DEST_W-1:0]   dest_col;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             outside;
    } t_out_beat;

    typedef struct packed {
        logic                is_load;
        logic [LOAD_X_W-1:0] ld_x;
        logic [LOAD_Y_W-1:0] ld_y;
        logic [PIX_W-1:0]    ld_pix;
    } t_meta;

    typedef struct packed {
        t_meta         meta;
        logic          negx;
        logic          negy;
        logic          zero;
        logic          ovx;
        logic          ovy;
        logic [NW-1:0] b;
        logic [NW-1:0] remx;
        logic [NW-1:0] remy;
        logic [QB-1:0] qx;
        logic [QB-1:0] qy;
    } t_div;

endpackage
`default_nettype wire

// ===== rtl/perspective_warp_nearest_sampler.sv =====
// Perspective warp sampler: projective mapping, pipelined divider, source image RAM.
// Throughput: one beat per cycle, loads and samples alike, unless a stalled output holds
// the pipeline; set by the fully pipelined restoring divider (one quotient bit per stage,
// x and y side by side). Path of a sample: products, sums, rounding, QB divide stages,
// address, RAM read, output register. Loads write the RAM at the same stage a sample reads it.
// Reset (synchronous, active low) clears valids and sets configuration to its defaults; image RAM is not cleared.
`default_nettype none
module perspective_warp_nearest_sampler (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  pwns_pkg::t_in_beat               i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output pwns_pkg::t_out_beat              o_out_data,
    input  wire                              i_cfg_wr_en,
    input  wire [pwns_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [pwns_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pwns_pkg::*;
    `include "assert_macros.svh"

    // ---------------- configuration ----------------
    // r_m[0..8] hold m0..m8 in signed Q16.16; scale cancels in the quotient
    logic signed [COEF_W-1:0] r_m [9];
    logic [PIX_W-1:0]         r_border;
    logic [CFG_SIZE_W-1:0]    r_src_w;
    logic [CFG_SIZE_W-1:0]    r_src_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_m[i] <= '0;
            end
            r_m[8]   <= COEF_W'(65536);
            r_border <= PIX_W'(128);
            r_src_w  <= CFG_SIZE_W'(512);
            r_src_h  <= CFG_SIZE_W'(512);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_COEF_M0_M1: begin
                    r_m[0] <= i_cfg_data[63:32];
                    r_m[1] <= i_cfg_data[31:0];
                end
                CFG_COEF_M2_M3: begin
                    r_m[2] <= i_cfg_data[63:32];
                    r_m[3] <= i_cfg_data[31:0];
                end
                CFG_COEF_M4_M5: begin
                    r_m[4] <= i_cfg_data[63:32];
                    r_m[5] <= i_cfg_data[31:0];
                end
                CFG_COEF_M6_M7: begin
                    r_m[6] <= i_cfg_data[63:32];
                    r_m[7] <= i_cfg_data[31:0];
                end
                CFG_COEF_M8:       r_m[8]   <= i_cfg_data[COEF_W-1:0];
                CFG_BORDER_VALUE:  r_border <= i_cfg_data[PIX_W-1:0];
                CFG_SOURCE_WIDTH:  r_src_w  <= i_cfg_data[CFG_SIZE_W-1:0];
                CFG_SOURCE_HEIGHT: r_src_h  <= i_cfg_data[CFG_SIZE_W-1:0];
            endcase
        end
    end

    // size in use: min(register, memory side)
    logic [CW-1:0] wuse;
    logic [CW-1:0] huse;
    assign wuse = (CW'(r_src_w) > CW'(SRC_MAX_WIDTH))  ? CW'(SRC_MAX_WIDTH)  : CW'(r_src_w);
    assign huse = (CW'(r_src_h) > CW'(SRC_MAX_HEIGHT)) ? CW'(SRC_MAX_HEIGHT) : CW'(r_src_h);

    // ---------------- pipeline control ----------------
    // One enable moves every stage. It holds only when a result waits at the
    // output, is not being taken, and another result sits right behind it,
    // so bubbles are squeezed out even while the consumer stalls.
    logic en;
    logic accept;

    logic        rm_vld;       // sample at the RAM stage
    logic        r_out_vld;

    assign en         = !r_out_vld || i_out_ready || !rm_vld;
    assign o_in_ready = en;
    assign accept     = i_in_valid && en;

    // ---------------- stage 1: products ----------------
    logic                 r1_vld;
    t_meta                r1_meta;
    logic signed [PW-1:0] r1_p [6];

    logic signed [DEST_W:0] colx;
    logic signed [DEST_W:0] rowx;
    logic                   dest_ok;
    t_meta                  n_meta;

    assign colx    = $signed({1'b0, i_in_data.dest_col});
    assign rowx    = $signed({1'b0, i_in_data.dest_row});
    assign dest_ok = ({1'b0, i_in_data.dest_col} < (DEST_W+1)'(DEST_SIZE)) &&
                     ({1'b0, i_in_data.dest_row} < (DEST_W+1)'(DEST_SIZE));

    always_comb begin
        n_meta.is_load = (i_in_data.operation == OP_LOAD);
        n_meta.ld_x    = i_in_data.load_x;
        n_meta.ld_y    = i_in_data.load_y;
        n_meta.ld_pix  = i_in_data.load_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            // out-of-range destinations give no result: dropped here
            r1_vld <= accept && (n_meta.is_load || dest_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_meta  <= n_meta;
            r1_p[0]  <= PW'(r_m[0]) * PW'(colx);
            r1_p[1]  <= PW'(r_m[1]) * PW'(rowx);
            r1_p[2]  <= PW'(r_m[3]) * PW'(colx);
            r1_p[3]  <= PW'(r_m[4]) * PW'(rowx);
            r1_p[4]  <= PW'(r_m[6]) * PW'(colx);
            r1_p[5]  <= PW'(r_m[7]) * PW'(rowx);
        end
    end

    // ---------------- stage 2: numerators and denominator ----------------
    logic                 r2_vld;
    t_meta                r2_meta;
    logic signed [SW-1:0] r2_numx;
    logic signed [SW-1:0] r2_numy;
    logic signed [SW-1:0] r2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_meta <= r1_meta;
            r2_numx <= SW'(r1_p[0]) + SW'(r1_p[1]) + SW'(r_m[2]);
            r2_numy <= SW'(r1_p[2]) + SW'(r1_p[3]) + SW'(r_m[5]);
            r2_den  <= SW'(r1_p[4]) + SW'(r1_p[5]) + SW'(r_m[8]);
        end
    end

    // ---------------- stage 3: round-half terms, magnitudes ----------------
    // q = trunc((2*num + den) / (2*den)); divide magnitudes, fix sign after
    logic                 r3_vld;
    t_meta                r3_meta;
    logic [NW-1:0]        r3_ax;
    logic [NW-1:0]        r3_ay;
    logic [NW-1:0]        r3_b;
    logic                 r3_negx;
    logic                 r3_negy;
    logic                 r3_zero;

    logic signed [NW-1:0] n_nx;
    logic signed [NW-1:0] n_ny;
    logic signed [NW-1:0] n_d;

    assign n_nx = (NW'(r2_numx) <<< 1) + NW'(r2_den);
    assign n_ny = (NW'(r2_numy) <<< 1) + NW'(r2_den);
    assign n_d  = NW'(r2_den) <<< 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_meta <= r2_meta;
            r3_ax   <= n_nx[NW-1] ? unsigned'(-n_nx) : unsigned'(n_nx);
            r3_ay   <= n_ny[NW-1] ? unsigned'(-n_ny) : unsigned'(n_ny);
            r3_b    <= n_d[NW-1]  ? unsigned'(-n_d)  : unsigned'(n_d);
            r3_negx <= n_nx[NW-1] ^ n_d[NW-1];
            r3_negy <= n_ny[NW-1] ^ n_d[NW-1];
            r3_zero <= (r2_den == '0);
        end
    end

    // ---------------- divide stages: one quotient bit each ----------------
    logic        r_dv_vld [QB];
    t_div        r_dv     [QB];
    t_div        n_src    [QB];
    t_div        n_dv     [QB];

    function automatic logic [NW:0] div_bit(input logic [NW-1:0] rem,
                                            input logic [NW-1:0] b, input int sh);
        logic [DW-1:0] bs;
        logic [NW:0]   res;
        bs  = DW'(b) << sh;
        res = {1'b0, rem};
        if (DW'(rem) >= bs) begin
            res = {1'b1, rem - bs[NW-1:0]};
        end
        return res;
    endfunction

    always_comb begin
        logic [NW:0] sx;
        logic [NW:0] sy;
        // first stage also flags quotients that cannot fit in QB bits
        n_src[0].meta = r3_meta;
        n_src[0].negx = r3_negx;
        n_src[0].negy = r3_negy;
        n_src[0].zero = r3_zero;
        n_src[0].ovx  = DW'(r3_ax) >= (DW'(r3_b) << QB);
        n_src[0].ovy  = DW'(r3_ay) >= (DW'(r3_b) << QB);
        n_src[0].b    = r3_b;
        n_src[0].remx = r3_ax;
        n_src[0].remy = r3_ay;
        n_src[0].qx   = '0;
        n_src[0].qy   = '0;
        for (int k = 1; k < QB; k++) begin
            n_src[k] = r_dv[k-1];
        end
        for (int k = 0; k < QB; k++) begin
            n_dv[k] = n_src[k];
            sx = div_bit(n_src[k].remx, n_src[k].b, QB - 1 - k);
            sy = div_bit(n_src[k].remy, n_src[k].b, QB - 1 - k);
            n_dv[k].remx = sx[NW-1:0];
            n_dv[k].remy = sy[NW-1:0];
            n_dv[k].qx[QB-1-k] = sx[NW];
            n_dv[k].qy[QB-1-k] = sy[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QB; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv_vld[0] <= r3_vld;
            for (int k = 1; k < QB; k++) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < QB; k++) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    // ---------------- address stage ----------------
    logic              ra_vld;
    logic              ra_write;
    logic              ra_sample;
    logic              ra_inside;
    logic [MEM_AW-1:0] ra_addr;
    logic [PIX_W-1:0]  ra_pix;

    t_div              dl;
    logic              n_inx;
    logic              n_iny;
    logic              n_ld_ok;

    assign dl      = r_dv[QB-1];
    // a negative quotient is inside only when it rounds to zero
    assign n_inx   = !dl.ovx && (!dl.negx || dl.qx == '0) && (CW'(dl.qx) < wuse);
    assign n_iny   = !dl.ovy && (!dl.negy || dl.qy == '0) && (CW'(dl.qy) < huse);
    assign n_ld_ok = ({1'b0, dl.meta.ld_x} < (LOAD_X_W+1)'(SRC_MAX_WIDTH)) &&
                     ({1'b0, dl.meta.ld_y} < (LOAD_Y_W+1)'(SRC_MAX_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld <= 1'b0;
        end else if (en) begin
            ra_vld <= r_dv_vld[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra_write  <= dl.meta.is_load && n_ld_ok;
            ra_sample <= !dl.meta.is_load;
            ra_inside <= !dl.zero && n_inx && n_iny;
            ra_pix    <= dl.meta.ld_pix;
            if (dl.meta.is_load) begin
                ra_addr <= MEM_AW'(dl.meta.ld_y) * MEM_AW'(SRC_MAX_WIDTH)
                           + MEM_AW'(dl.meta.ld_x);
            end else begin
                ra_addr <= MEM_AW'(dl.qy[LOAD_Y_W-1:0]) * MEM_AW'(SRC_MAX_WIDTH)
                           + MEM_AW'(dl.qx[LOAD_X_W-1:0]);
            end
        end
    end

    // ---------------- image RAM stage ----------------
    // Loads and samples reach this stage in acceptance order, one per cycle unless
    // the output stalls, so a write and a later read of the same pixel never overlap.
    logic [PIX_W-1:0] mem_img [MEM_DEPTH];
    logic [PIX_W-1:0] r_rd;
    logic             rm_inside;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (ra_vld && ra_write) begin
                mem_img[ra_addr] <= ra_pix;
            end
            r_rd <= mem_img[ra_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_vld <= 1'b0;
        end else if (en) begin
            rm_vld <= ra_vld && ra_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rm_inside <= ra_inside;
        end
    end

    // ---------------- output register ----------------
    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en && rm_vld) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && rm_vld) begin
            r_out.pixel_out <= rm_inside ? r_rd : r_border;
            r_out.outside   <= !rm_inside;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ---------------- checks ----------------
    `ASSERT_HOLDS(a_ready_when_out_free, i_clk, i_rst_n, !r_out_vld |-> o_in_ready)
    `ASSERT_NEXT(a_sample_reaches_out, i_clk, i_rst_n, en && rm_vld, r_out_vld)
    `ASSERT_NEXT(a_stall_keeps_ram_stage, i_clk, i_rst_n, !en && rm_vld, rm_vld)
    `ASSERT_HOLDS(a_stall_only_when_full, i_clk, i_rst_n,
        !en |-> (r_out_vld && rm_vld && !i_out_ready))

endmodule
`default_nettype wire
